/* rtl/core/pmfb_pkg.sv */
package pmfb_pkg;

  localparam int SCREEN_COLS  = 84;
  localparam int SCREEN_PAGES = 6;
  localparam int STORE_BYTES  = SCREEN_COLS * SCREEN_PAGES;
  localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  // wide enough for column + page * SCREEN_COLS at any legal geometry
  localparam int CALC_W       = 16;

  typedef enum logic [2:0] {
    KIND_SET       = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_TOGGLE    = 3'd2,
    KIND_COLUMN    = 3'd3,
    KIND_CLEAR_ALL = 3'd4,
    KIND_READ      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO,
    ST_HI
  } state_t;

endpackage

/* rtl/core/pmfb_cmd_if.sv */
interface pmfb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [8:0] x;
  logic signed [8:0] y;
  logic [7:0]        data;

  modport source (output valid, kind, x, y, data, input ready);
  modport sink   (input valid, kind, x, y, data, output ready);
endinterface

/* rtl/core/pmfb_rsp_if.sv */
interface pmfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       clipped;

  modport source (output valid, read_data, clipped, input ready);
  modport sink   (input valid, read_data, clipped, output ready);
endinterface

/* rtl/core/paged_mono_framebuffer.sv */
// Timing: a command's byte is read on acceptance in ST_IDLE, then merged and written back
//   in ST_LO (and ST_HI for a two-page column write); the response is registered once the
//   response slot is free. A new command is accepted only in ST_IDLE, after the last one
//   has finished; clear all zeroes every byte of the store in ST_CLEAR before it responds.
// Reset: rst (sync, active high) starts a pass that zeroes the store;
//   cmd.ready stays low until it finishes.
module paged_mono_framebuffer import pmfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  pmfb_cmd_if.sink   cmd,
  pmfb_rsp_if.source rsp
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // frame store
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_rdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // control
  state_t            state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              clr_reply, clr_reply_next;
  logic              out_valid;
  logic [7:0]        out_read_data;
  logic              out_clipped;

  // held operation
  logic [ADDR_W-1:0] op_addr_lo, op_addr_hi;
  logic [7:0]        op_mask_lo, op_val_lo, op_mask_hi, op_val_hi;
  logic              op_tog, op_we_lo, op_we_hi, op_read, op_clip;

  // command decode
  logic              accept;
  logic              x_ok, lo_ok, hi_ok, spans;
  logic [9:0]        y_hi;
  logic [2:0]        shift;
  logic [15:0]       data_shift;
  logic [CALC_W-1:0] addr_lo_wide, addr_hi_wide;
  logic [7:0]        d_mask_lo, d_val_lo, d_mask_hi, d_val_hi;
  logic              d_tog, d_we_lo, d_we_hi, d_read, d_clip;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);

  assign x_ok  = !cmd.x[8] && ({1'b0, cmd.x[7:0]} < 9'(SCREEN_COLS));
  assign lo_ok = !cmd.y[8] && ({1'b0, cmd.y[7:3]} < 6'(SCREEN_PAGES));
  assign y_hi  = {cmd.y[8], cmd.y} + 10'd8;
  assign hi_ok = !y_hi[9] && ({1'b0, y_hi[8:3]} < 7'(SCREEN_PAGES));
  assign shift = cmd.y[2:0];
  assign spans = (shift != 3'd0);
  assign data_shift = {8'h00, cmd.data} << shift;

  assign addr_lo_wide = CALC_W'(cmd.x[7:0]) + CALC_W'(cmd.y[7:3]) * CALC_W'(SCREEN_COLS);
  assign addr_hi_wide = CALC_W'(cmd.x[7:0]) + CALC_W'(y_hi[8:3]) * CALC_W'(SCREEN_COLS);

  always_comb begin
    d_mask_lo = 8'h00;
    d_val_lo  = 8'h00;
    d_mask_hi = 8'h00;
    d_val_hi  = 8'h00;
    d_tog     = 1'b0;
    d_we_lo   = 1'b0;
    d_we_hi   = 1'b0;
    d_read    = 1'b0;
    d_clip    = 1'b0;
    unique case (kind_t'(cmd.kind))
      KIND_SET, KIND_CLEAR, KIND_TOGGLE: begin
        d_mask_lo = 8'h01 << shift;
        d_val_lo  = (kind_t'(cmd.kind) == KIND_SET) ? d_mask_lo : 8'h00;
        d_tog     = (kind_t'(cmd.kind) == KIND_TOGGLE);
        d_we_lo   = x_ok && lo_ok;
        d_clip    = !(x_ok && lo_ok);
      end
      KIND_COLUMN: begin
        d_mask_lo = 8'hFF << shift;
        d_val_lo  = data_shift[7:0];
        d_mask_hi = ~d_mask_lo;
        d_val_hi  = data_shift[15:8];
        d_we_lo   = x_ok && lo_ok;
        d_we_hi   = x_ok && hi_ok && spans;
        d_clip    = !x_ok || !lo_ok || (spans && !hi_ok);
      end
      KIND_READ: begin
        d_read = 1'b1;
        d_clip = !(x_ok && lo_ok);
      end
      default: begin
      end
    endcase
  end

  // merged bytes
  logic [7:0] new_lo, new_hi;
  logic       slot_free;

  assign new_lo = (mem_rdata & ~op_mask_lo) | ((op_tog ? ~mem_rdata : op_val_lo) & op_mask_lo);
  assign new_hi = (mem_rdata & ~op_mask_hi) | (op_val_hi & op_mask_hi);
  assign slot_free = !out_valid || rsp.ready;

  logic       push;
  logic [7:0] push_rd;
  logic       push_clip;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    clr_reply_next = clr_reply;
    mem_re         = 1'b0;
    mem_raddr      = addr_lo_wide[ADDR_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = op_addr_lo;
    mem_wdata      = new_lo;
    push           = 1'b0;
    push_rd        = 8'h00;
    push_clip      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = 8'h00;
        if (cnt == LAST_ADDR) begin
          if (!clr_reply) begin
            state_next = ST_IDLE;
          end else if (slot_free) begin
            push           = 1'b1;
            clr_reply_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (kind_t'(cmd.kind) == KIND_CLEAR_ALL) begin
            cnt_next       = '0;
            clr_reply_next = 1'b1;
            state_next     = ST_CLEAR;
          end else begin
            mem_re     = 1'b1;
            state_next = ST_LO;
          end
        end
      end
      ST_LO: begin
        if (op_we_hi) begin
          // first page written now, second page read for the next cycle
          mem_we     = op_we_lo;
          mem_re     = 1'b1;
          mem_raddr  = op_addr_hi;
          state_next = ST_HI;
        end else if (slot_free) begin
          mem_we     = op_we_lo;
          push       = 1'b1;
          push_rd    = (op_read && !op_clip) ? mem_rdata : 8'h00;
          push_clip  = op_clip;
          state_next = ST_IDLE;
        end
      end
      ST_HI: begin
        if (slot_free) begin
          mem_we     = 1'b1;
          mem_waddr  = op_addr_hi;
          mem_wdata  = new_hi;
          push       = 1'b1;
          push_clip  = op_clip;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      clr_reply <= clr_reply_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_addr_lo <= addr_lo_wide[ADDR_W-1:0];
      op_addr_hi <= addr_hi_wide[ADDR_W-1:0];
      op_mask_lo <= d_mask_lo;
      op_val_lo  <= d_val_lo;
      op_mask_hi <= d_mask_hi;
      op_val_hi  <= d_val_hi;
      op_tog     <= d_tog;
      op_we_lo   <= d_we_lo;
      op_we_hi   <= d_we_hi;
      op_read    <= d_read;
      op_clip    <= d_clip;
    end
    if (push) begin
      out_read_data <= push_rd;
      out_clipped   <= push_clip;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_read_data;
  assign rsp.clipped   = out_clipped;

`ifndef SYNTHESIS
  // a waiting response is never overwritten
  assert property (@(posedge clk) disable iff (rst) push |-> slot_free)
    else $error("response register overwritten");

  // no store write while waiting for a command
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // second page is only reached from the first
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_HI) |-> ($past(state) == ST_LO || $past(state) == ST_HI))
    else $error("second page step without first page step");

  // clearing pass blocks commands right after reset
  assert property (@(posedge clk) $past(rst) |-> !cmd.ready)
    else $error("command accepted before store cleared");
`endif

endmodule
